@@ rtl/core/kcl_pkg.sv @@
package kcl_pkg;

	localparam int unsigned TABLE_DEPTH = 5;
	localparam int unsigned MAX_DIGITS  = 4;

	localparam int unsigned ENTRY_W = 14;
	localparam int unsigned CNT_W   = 3;
	localparam int unsigned KEY_W   = 5;
	localparam int unsigned OP_W    = 2;
	localparam int unsigned STAT_W  = 3;

	localparam logic [ENTRY_W-1:0] CODE_RESET  = ENTRY_W'(1234);
	localparam logic [ENTRY_W-1:0] ADMIN_RESET = ENTRY_W'(1111);
	localparam logic [CNT_W-1:0]   DIGITS_FULL = CNT_W'(MAX_DIGITS);

	localparam logic [KEY_W-1:0] KEY_DIGIT_ONE  = KEY_W'(1);
	localparam logic [KEY_W-1:0] KEY_DIGIT_ZERO = KEY_W'(10);
	localparam logic [KEY_W-1:0] KEY_CONFIRM    = KEY_W'(11);
	localparam logic [KEY_W-1:0] KEY_CANCEL     = KEY_W'(12);

	typedef enum logic [OP_W-1:0] {
		OP_USER   = 2'd0,
		OP_ADMIN  = 2'd1,
		OP_ENROLL = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_IDLE      = 3'd0,
		STAT_UNLOCK    = 3'd1,
		STAT_DENIED    = 3'd2,
		STAT_ADMIN_OK  = 3'd3,
		STAT_ADMIN_BAD = 3'd4,
		STAT_ENROLLED  = 3'd5,
		STAT_CANCELLED = 3'd6,
		STAT_CLEARED   = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		ACT_NONE   = 3'd0,
		ACT_DIGIT  = 3'd1,
		ACT_USER   = 3'd2,
		ACT_ADMIN  = 3'd3,
		ACT_ENROLL = 3'd4,
		ACT_CANCEL = 3'd5,
		ACT_CLEAR  = 3'd6
	} act_t;

	typedef struct packed {
		logic       load;
		act_t       act;
		logic [3:0] digit;
	} cmd_t;

	typedef struct packed {
		logic entry_full;
	} sts_t;

endpackage

@@ rtl/core/kcl_if.sv @@
interface kcl_in_if;
	import kcl_pkg::*;

	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  operation;
	logic [KEY_W-1:0] key_code;

	modport source (output valid, output operation, output key_code, input ready);
	modport sink (input valid, input operation, input key_code, output ready);
endinterface

interface kcl_out_if;
	import kcl_pkg::*;

	logic               valid;
	logic               ready;
	logic [STAT_W-1:0]  status;
	logic [ENTRY_W-1:0] entry_value;
	logic [CNT_W-1:0]   digit_count;

	modport source (output valid, output status, output entry_value, output digit_count,
		input ready);
	modport sink (input valid, input status, input entry_value, input digit_count,
		output ready);
endinterface

interface kcl_cfg_if;
	import kcl_pkg::*;

	logic               valid;
	logic               ready;
	logic [ENTRY_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/kcl_ctrl.sv @@
module kcl_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	input  logic [kcl_pkg::OP_W-1:0]  operation,
	input  logic [kcl_pkg::KEY_W-1:0] key_code,
	output logic                     req_ready,
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	input  kcl_pkg::sts_t            sts,
	output kcl_pkg::cmd_t            cmd
);
	import kcl_pkg::*;

	typedef enum logic [1:0] {
		ST_EMPTY = 2'b01,
		ST_FULL  = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   accept;
	act_t   act;

	assign rsp_valid = (state_q == ST_FULL);
	assign req_ready = (state_q == ST_EMPTY) || rsp_ready;
	assign accept    = req_valid && req_ready;

	// decode the key event against the operation
	always_comb begin
		act = ACT_NONE;
		if (op_t'(operation) == OP_CLEAR) begin
			act = ACT_CLEAR;
		end else if (key_code >= KEY_DIGIT_ONE && key_code <= KEY_DIGIT_ZERO) begin
			// drop digits once the entry is full
			act = sts.entry_full ? ACT_NONE : ACT_DIGIT;
		end else if (key_code == KEY_CONFIRM) begin
			case (op_t'(operation))
				OP_USER:  act = ACT_USER;
				OP_ADMIN: act = ACT_ADMIN;
				default:  act = ACT_ENROLL;
			endcase
		end else if (key_code == KEY_CANCEL) begin
			act = ACT_CANCEL;
		end
	end

	always_comb begin
		cmd.load  = accept;
		cmd.act   = act;
		cmd.digit = (key_code == KEY_DIGIT_ZERO) ? 4'd0 : key_code[3:0];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_EMPTY: begin
				if (accept) state_d = ST_FULL;
			end
			ST_FULL: begin
				if (!accept && rsp_ready) state_d = ST_EMPTY;
			end
			default: state_d = ST_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/core/kcl_dp.sv @@
module kcl_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  kcl_pkg::cmd_t               cmd,
	input  logic                        cfg_we,
	input  logic [kcl_pkg::ENTRY_W-1:0] cfg_data,
	output kcl_pkg::sts_t               sts,
	output logic [kcl_pkg::STAT_W-1:0]  status,
	output logic [kcl_pkg::ENTRY_W-1:0] entry_value,
	output logic [kcl_pkg::CNT_W-1:0]   digit_count
);
	import kcl_pkg::*;

	logic [ENTRY_W-1:0] table_q [TABLE_DEPTH];
	logic [ENTRY_W-1:0] table_d [TABLE_DEPTH];
	logic [ENTRY_W-1:0] admin_q;
	logic [ENTRY_W-1:0] accum_q, accum_d;
	logic [CNT_W-1:0]   digits_q, digits_d;
	status_t            stat_d;
	logic [STAT_W-1:0]  status_q;
	logic [ENTRY_W-1:0] value_q;
	logic [CNT_W-1:0]   count_q;
	logic               match;
	logic [ENTRY_W-1:0] times_ten;

	assign sts.entry_full = (digits_q >= DIGITS_FULL);
	assign times_ten      = (accum_q << 3) + (accum_q << 1);

	// parallel compare against every stored code
	always_comb begin
		match = 1'b0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (table_q[i] == accum_q) match = 1'b1;
		end
	end

	always_comb begin
		accum_d  = accum_q;
		digits_d = digits_q;
		stat_d   = STAT_IDLE;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			table_d[i] = table_q[i];
		end
		case (cmd.act)
			ACT_DIGIT: begin
				accum_d  = times_ten + ENTRY_W'(cmd.digit);
				digits_d = digits_q + CNT_W'(1);
			end
			ACT_USER: begin
				stat_d   = match ? STAT_UNLOCK : STAT_DENIED;
				accum_d  = '0;
				digits_d = '0;
			end
			ACT_ADMIN: begin
				stat_d   = (accum_q == admin_q) ? STAT_ADMIN_OK : STAT_ADMIN_BAD;
				accum_d  = '0;
				digits_d = '0;
			end
			ACT_ENROLL: begin
				// insert at the front, drop the oldest code
				for (int i = TABLE_DEPTH - 1; i > 0; i--) begin
					table_d[i] = table_q[i-1];
				end
				table_d[0] = accum_q;
				stat_d     = STAT_ENROLLED;
				accum_d    = '0;
				digits_d   = '0;
			end
			ACT_CANCEL: begin
				stat_d   = STAT_CANCELLED;
				accum_d  = '0;
				digits_d = '0;
			end
			ACT_CLEAR: begin
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					table_d[i] = '0;
				end
				stat_d = STAT_CLEARED;
			end
			default: begin
				stat_d = STAT_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				table_q[i] <= CODE_RESET;
			end
			accum_q  <= '0;
			digits_q <= '0;
		end else if (cmd.load) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				table_q[i] <= table_d[i];
			end
			accum_q  <= accum_d;
			digits_q <= digits_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			admin_q <= ADMIN_RESET;
		end else if (cfg_we) begin
			admin_q <= cfg_data;
		end
	end

	// result register, held until taken
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q <= stat_d;
			value_q  <= accum_d;
			count_q  <= digits_d;
		end
	end

	assign status      = status_q;
	assign entry_value = value_q;
	assign digit_count = count_q;

endmodule

@@ rtl/core/keypad_code_lock.sv @@
// A result item appears in the cycle after its key item is accepted.
// Throughput: one item per cycle while results are taken; the single result
// register stalls the input only when it is full and not being taken.
// Reset: every code table entry is 1234, admin code 1111, the entry is empty
// and no result is pending.
module keypad_code_lock (
	input  logic      clk,
	input  logic      arst_n,
	kcl_in_if.sink    req,
	kcl_out_if.source rsp,
	kcl_cfg_if.sink   cfg
);
	import kcl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	kcl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.operation (req.operation),
		.key_code  (req.key_code),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	kcl_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg.valid),
		.cfg_data    (cfg.data),
		.sts         (sts),
		.status      (rsp.status),
		.entry_value (rsp.entry_value),
		.digit_count (rsp.digit_count)
	);

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.digit_count <= DIGITS_FULL)
		else $error("digit count beyond entry length");

	a_empty_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.digit_count == '0 |-> rsp.entry_value == '0)
		else $error("empty entry with non-zero value");

	a_confirm_clears: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != STAT_IDLE && rsp.status != STAT_CLEARED
		|-> rsp.digit_count == '0)
		else $error("entry not cleared on confirm or cancel");

	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> rsp.valid)
		else $error("accepted item produced no result");
`endif

endmodule

@@ sim/keypad_code_lock_tb.sv @@
module keypad_code_lock_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kcl_pkg::*;

	localparam logic [KEY_W-1:0] KEY_NONE        = '0;
	localparam logic [KEY_W-1:0] KEY_TOP         = '1;
	localparam logic [KEY_W-1:0] KEY_FIRST_SPARE = KEY_W'(13);
	localparam int MAX_REPORTS   = 10;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_ITEMS   = 100;

	typedef struct packed {
		status_t            status;
		logic [ENTRY_W-1:0] value;
		logic [CNT_W-1:0]   count;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n;

	kcl_in_if  req_if ();
	kcl_out_if rsp_if ();
	kcl_cfg_if cfg_if ();

	keypad_code_lock dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	// lock state as the block should hold it
	logic [ENTRY_W-1:0] code_tab [TABLE_DEPTH];
	logic [ENTRY_W-1:0] entry_acc;
	logic [CNT_W-1:0]   entry_cnt;
	logic [ENTRY_W-1:0] admin_now;

	reply_t reply_q [$];

	int errors          = 0;
	int items_sent      = 0;
	int replies_checked = 0;
	int admin_writes    = 0;
	int hold_left       = 0;
	int stall_left      = 0;
	int status_seen [8];
	bit tx_idle_on;
	bit rx_idle_on;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void flag_error(string msg);
		errors++;
		if (errors <= MAX_REPORTS) begin
			$display("mismatch: %s", msg);
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			return $urandom_range(1, 3);
		end
		if (r < 95) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic reply_t compute_reply(op_t op, logic [KEY_W-1:0] key);
		reply_t r;
		bit hit;
		r.status = STAT_IDLE;
		if (op == OP_CLEAR) begin
			// the entry survives a table clear
			foreach (code_tab[i]) code_tab[i] = '0;
			r.status = STAT_CLEARED;
		end else if (key >= KEY_DIGIT_ONE && key <= KEY_DIGIT_ZERO) begin
			if (entry_cnt < DIGITS_FULL) begin
				entry_acc = ENTRY_W'(entry_acc * 10 + key % 10);
				entry_cnt++;
			end
		end else if (key == KEY_CONFIRM) begin
			case (op)
			OP_USER: begin
				hit = 1'b0;
				foreach (code_tab[i]) if (code_tab[i] == entry_acc) hit = 1'b1;
				r.status = hit ? STAT_UNLOCK : STAT_DENIED;
			end
			OP_ADMIN: begin
				r.status = (entry_acc == admin_now) ? STAT_ADMIN_OK : STAT_ADMIN_BAD;
			end
			default: begin
				// newest code at the front, oldest falls off the end
				for (int i = int'(TABLE_DEPTH) - 1; i > 0; i--) code_tab[i] = code_tab[i - 1];
				code_tab[0] = entry_acc;
				r.status = STAT_ENROLLED;
			end
			endcase
			entry_acc = '0;
			entry_cnt = '0;
		end else if (key == KEY_CANCEL) begin
			entry_acc = '0;
			entry_cnt = '0;
			r.status = STAT_CANCELLED;
		end
		r.value = entry_acc;
		r.count = entry_cnt;
		return r;
	endfunction

	// valid is left high when the next item follows at once
	task automatic send_key(op_t op, logic [KEY_W-1:0] key);
		int gap;
		reply_t r;
		req_if.valid     <= 1'b1;
		req_if.operation <= op;
		req_if.key_code  <= key;
		do @(posedge clk); while (!req_if.ready);
		r = compute_reply(op, key);
		reply_q.push_back(r);
		status_seen[r.status]++;
		items_sent++;
		gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic type_code(op_t op, int value, int ndig);
		int d;
		for (int i = ndig - 1; i >= 0; i--) begin
			d = (value / 10 ** i) % 10;
			send_key(op, d == 0 ? KEY_DIGIT_ZERO : KEY_W'(d));
		end
	endtask

	task automatic drain_replies();
		req_if.valid <= 1'b0;
		while (reply_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_admin(logic [ENTRY_W-1:0] code);
		drain_replies();
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= code;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		admin_now = code;
		admin_writes++;
	endtask

	task automatic test_entry_and_unlock();
		send_key(OP_USER, KEY_CONFIRM);
		send_key(OP_USER, KEY_NONE);
		send_key(OP_USER, KEY_TOP);
		// fifth digit is dropped, leaving the reset code
		type_code(OP_USER, 12349, 5);
		send_key(OP_USER, KEY_CONFIRM);
	endtask

	task automatic test_admin_and_cancel();
		type_code(OP_ADMIN, ADMIN_RESET, 4);
		send_key(OP_ADMIN, KEY_CONFIRM);
		send_key(OP_ADMIN, KEY_DIGIT_ZERO);
		send_key(OP_ADMIN, KEY_FIRST_SPARE);
		send_key(OP_ADMIN, KEY_CANCEL);
	endtask

	task automatic test_enroll_and_clear();
		type_code(OP_ENROLL, 9, 1);
		send_key(OP_ENROLL, KEY_CONFIRM);
		type_code(OP_USER, 9, 1);
		send_key(OP_USER, KEY_CONFIRM);
		type_code(OP_USER, 7, 1);
		send_key(OP_CLEAR, KEY_W'(5));
		send_key(OP_USER, KEY_CONFIRM);
		// empty entry matches a zeroed table
		send_key(OP_USER, KEY_CONFIRM);
	endtask

	task automatic test_admin_register();
		write_admin('0);
		send_key(OP_ADMIN, KEY_CONFIRM);
		write_admin('1);
		send_key(OP_ADMIN, KEY_CONFIRM);
	endtask

	task automatic test_stalled_output();
		drain_replies();
		tx_idle_on = 1'b0;
		hold_left = 80;
		repeat (20) begin
			send_key(op_t'($urandom_range(OP_USER, OP_ENROLL)),
				KEY_W'($urandom_range(KEY_DIGIT_ONE, KEY_CANCEL)));
		end
		drain_replies();
	endtask

	task automatic run_random_phase(int n);
		int done;
		int pick;
		int ndig;
		int value;
		op_t op;
		logic [KEY_W-1:0] key;
		done = 0;
		while (done < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				// half the time a code the lock knows, so matches actually happen
				op = op_t'($urandom_range(OP_USER, OP_ENROLL));
				case ($urandom_range(0, 3))
				0: value = code_tab[$urandom_range(0, TABLE_DEPTH - 1)];
				1: value = admin_now % 10000;
				default: value = $urandom_range(0, 9999);
				endcase
				ndig = ($urandom_range(0, 3) != 0) ? 4 : $urandom_range(0, 5);
				type_code(op, value, ndig);
				send_key(op, ($urandom_range(0, 9) == 0) ? KEY_CANCEL : KEY_CONFIRM);
				done += ndig + 1;
			end else if (pick < 75) begin
				send_key(OP_CLEAR, KEY_W'($urandom));
				done++;
			end else begin
				op = op_t'($urandom_range(OP_USER, OP_ENROLL));
				key = KEY_W'($urandom);
				send_key(op, key);
				if (key >= KEY_DIGIT_ONE && key <= KEY_CANCEL) begin
					done++;
				end
			end
		end
	endtask

	task automatic test_random_phases();
		logic [ENTRY_W-1:0] code;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
			0: code = ENTRY_W'(9999);
			1: code = '0;
			2: code = '1;
			3: code = ENTRY_W'($urandom_range(0, 9999));
			default: code = ADMIN_RESET;
			endcase
			write_admin(code);
			tx_idle_on = (p != 0);
			rx_idle_on = (p != 0 && p != 2);
			run_random_phase(PHASE_ITEMS);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			rsp_if.ready <= 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			rsp_if.ready <= 1'b0;
			stall_left--;
		end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
			rsp_if.ready <= 1'b0;
			stall_left = pick_gap() - 1;
		end else begin
			rsp_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_replies
		reply_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (reply_q.size() == 0) begin
				flag_error($sformatf("unexpected item: status %0d value %0d digits %0d",
					rsp_if.status, rsp_if.entry_value, rsp_if.digit_count));
			end else begin
				want = reply_q.pop_front();
				replies_checked++;
				if (rsp_if.status !== want.status || rsp_if.entry_value !== want.value
						|| rsp_if.digit_count !== want.count) begin
					flag_error($sformatf(
						"status %0d/%0d value %0d/%0d digits %0d/%0d (expected/actual)",
						want.status, rsp_if.status, want.value, rsp_if.entry_value,
						want.count, rsp_if.digit_count));
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("keypad_code_lock_tb NOT OK");
		$finish;
	end

	initial begin
		arst_n           = 1'b0;
		req_if.valid     = 1'b0;
		req_if.operation = OP_USER;
		req_if.key_code  = KEY_NONE;
		cfg_if.valid     = 1'b0;
		cfg_if.data      = '0;
		rsp_if.ready     = 1'b0;
		tx_idle_on       = 1'b1;
		rx_idle_on       = 1'b1;
		foreach (status_seen[i]) status_seen[i] = 0;
		admin_now = ADMIN_RESET;
		foreach (code_tab[i]) code_tab[i] = CODE_RESET;
		entry_acc = '0;
		entry_cnt = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_entry_and_unlock();
		test_admin_and_cancel();
		test_enroll_and_clear();
		test_admin_register();
		test_stalled_output();
		test_random_phases();
		drain_replies();

		$display("covered %0d key items, %0d replies checked, %0d admin code writes",
			items_sent, replies_checked, admin_writes);
		$display("unlock %0d/%0d, admin %0d/%0d, enrol %0d, cancel %0d, clear %0d",
			status_seen[STAT_UNLOCK], status_seen[STAT_DENIED],
			status_seen[STAT_ADMIN_OK], status_seen[STAT_ADMIN_BAD],
			status_seen[STAT_ENROLLED], status_seen[STAT_CANCELLED],
			status_seen[STAT_CLEARED]);
		if (errors == 0) begin
			$display("keypad_code_lock_tb OK");
		end else begin
			$display("keypad_code_lock_tb NOT OK");
		end
		$finish;
	end

endmodule
